// ===== design/pwf_pkg.sv =====
// ----------------------------------------------------------------------------
// pwf_pkg
// Shared constants and codes for the PCM to PWM sample FIFO.
// ----------------------------------------------------------------------------
package pwf_pkg;

   localparam int FIFO_DEPTH = 4096;
   localparam int OUT_BITS   = 8;
   localparam int PCM_BITS   = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int TOTAL_W    = 32;

   localparam logic [OUT_BITS-1:0] MIDSCALE = OUT_BITS'(128);

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

endpackage

// ===== design/pwf_ram.sv =====
// ----------------------------------------------------------------------------
// pwf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pwf_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pwf_conv.sv =====
// ----------------------------------------------------------------------------
// pwf_conv
// PCM to PWM code: optional stereo average (toward zero), offset, scale down.
// ----------------------------------------------------------------------------
module pwf_conv
   import pwf_pkg::*;
(
   input  logic                       stereo,
   input  logic signed [PCM_BITS-1:0] left_sample,
   input  logic signed [PCM_BITS-1:0] right_sample,
   output logic        [OUT_BITS-1:0] code
);

   logic signed [PCM_BITS:0]   sum;
   logic signed [PCM_BITS:0]   sum_adj;
   logic signed [PCM_BITS-1:0] mono;
   logic        [PCM_BITS-1:0] biased;

   always_comb begin
      sum     = {left_sample[PCM_BITS-1], left_sample}
              + {right_sample[PCM_BITS-1], right_sample};
      // round toward zero: add one before the shift when negative
      sum_adj = sum + {{PCM_BITS{1'b0}}, sum[PCM_BITS]};
      mono    = stereo ? sum_adj[PCM_BITS:1] : left_sample;
      biased  = {~mono[PCM_BITS-1], mono[PCM_BITS-2:0]};
      code    = biased[PCM_BITS-1:PCM_BITS-OUT_BITS];
   end

endmodule

// ===== design/pcm_to_pwm_sample_fifo_core.sv =====
// ----------------------------------------------------------------------------
// pcm_to_pwm_sample_fifo_core
// Audio sample FIFO feeding a PWM output, midscale fill on underrun.
// ----------------------------------------------------------------------------
// One request (push, pull, clear or no-op) is taken on every clock where start
// is high; busy stays low. Each request gives one response strobe on rsp_valid
// in the cycle after it is taken, matching the registered read of the sample
// ring memory. The ring needs no clearing pass after reset, and
// responses cannot be held off, so a new request may be issued in the same
// cycle a response is shown. stereo_mode is written through csr_valid/csr_wdata,
// always ready, between requests.
// ----------------------------------------------------------------------------
module pcm_to_pwm_sample_fifo_core
   import pwf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic signed [PCM_BITS-1:0] req_left_sample,
   input  logic signed [PCM_BITS-1:0] req_right_sample,
   input  logic                       req_last_in_call,
   output logic                       rsp_valid,
   output logic [OUT_BITS-1:0]        rsp_out_value,
   output logic                       rsp_accepted,
   output logic                       rsp_underran,
   output logic [CNT_W-1:0]           rsp_fill_level,
   output logic [CNT_W-1:0]           rsp_free_slots,
   output logic [TOTAL_W-1:0]         rsp_underrun_total,
   output logic [TOTAL_W-1:0]         rsp_overrun_total,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_wdata
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);

   logic               stereo_ff;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [TOTAL_W-1:0] under_cnt_ff, under_cnt_in;
   logic [TOTAL_W-1:0] over_cnt_ff, over_cnt_in;
   logic               drop_ff, drop_in;
   logic               rsp_valid_ff;
   logic               acc_ff, acc_in;
   logic               under_ff, under_in;
   logic               hit_ff, hit_in;

   logic               take;
   opcode_type         op;
   logic               wr_en;
   logic               rd_en;
   logic [OUT_BITS-1:0] code;
   logic [OUT_BITS-1:0] rd_data;

   assign take      = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign op        = opcode_type'(req_opcode);

   pwf_conv u_conv (
      .stereo       (stereo_ff),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .code         (code)
   );

   pwf_ram #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (OUT_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (code),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      held_in      = held_ff;
      under_cnt_in = under_cnt_ff;
      over_cnt_in  = over_cnt_ff;
      drop_in      = drop_ff;
      acc_in       = 1'b0;
      under_in     = 1'b0;
      hit_in       = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      if (take) begin
         case (op)
            OP_PUSH: begin
               if (drop_ff) begin
                  if (req_last_in_call) begin
                     drop_in = 1'b0;
                  end
               end else if (held_ff == DEPTH_CNT) begin
                  over_cnt_in = over_cnt_ff + 1'b1;
                  drop_in     = !req_last_in_call;
               end else begin
                  wr_en     = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
                  held_in   = held_ff + 1'b1;
                  acc_in    = 1'b1;
               end
            end
            OP_PULL: begin
               if (held_ff != '0) begin
                  rd_en     = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
                  held_in   = held_ff - 1'b1;
                  hit_in    = 1'b1;
               end else begin
                  under_in     = 1'b1;
                  under_cnt_in = under_cnt_ff + 1'b1;
               end
            end
            OP_CLEAR: begin
               wr_ptr_in    = '0;
               rd_ptr_in    = '0;
               held_in      = '0;
               under_cnt_in = '0;
               over_cnt_in  = '0;
               drop_in      = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff    <= 1'b1;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         held_ff      <= '0;
         under_cnt_ff <= '0;
         over_cnt_ff  <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 1'b0;
         under_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            stereo_ff <= csr_wdata;
         end
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         held_ff      <= held_in;
         under_cnt_ff <= under_cnt_in;
         over_cnt_ff  <= over_cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= take;
         acc_ff       <= acc_in;
         under_ff     <= under_in;
         hit_ff       <= hit_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_value      = hit_ff ? rd_data : (under_ff ? MIDSCALE : '0);
   assign rsp_accepted       = acc_ff;
   assign rsp_underran       = under_ff;
   assign rsp_fill_level     = held_ff;
   assign rsp_free_slots     = DEPTH_CNT - held_ff;
   assign rsp_underrun_total = under_cnt_ff;
   assign rsp_overrun_total  = over_cnt_ff;

   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("request without response");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= DEPTH_CNT)
      else $error("fill level above depth");

   a_underrun_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_underran |-> rsp_fill_level == '0 && rsp_out_value == MIDSCALE
         && !rsp_accepted)
      else $error("underrun with data held");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      held_ff != DEPTH_CNT && held_ff != '0 |-> wr_ptr_ff != rd_ptr_ff)
      else $error("ring pointers disagree with fill level");

endmodule

// ===== test/pcm_to_pwm_sample_fifo_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_to_pwm_sample_fifo_core_test
// Self-checking bench for the PCM to PWM audio sample FIFO.
//
// A queue of pending requests feeds a driver that presents them on falling
// edges with random idle gaps. A monitor samples every rising edge: it
// predicts the status of each accepted request from its own copy of the ring,
// pointers, counters and mixing mode, and compares every response field by
// field. Directed requests cover conversion extremes, rounding toward zero,
// every opcode, a full ring with overrun and drop-to-end-of-call, wrap of both
// pointers and underrun fill. Random phases run near empty with stereo mixing,
// near full with left only, and at mixed levels with stereo mixing.
// ----------------------------------------------------------------------------
module pcm_to_pwm_sample_fifo_core_test;
   import pwf_pkg::*;

   localparam int CLK_PERIOD       = 20;
   localparam int RUN_LIMIT_CYCLES = 300_000;
   localparam int MAX_PRINTED      = 40;

   typedef struct {
      opcode_type                 op;
      logic signed [PCM_BITS-1:0] left;
      logic signed [PCM_BITS-1:0] right;
      logic                       last;
      logic                       hold;
   } fifo_cmd_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                accepted;
      logic                underran;
      logic [CNT_W-1:0]    fill;
      logic [CNT_W-1:0]    free;
      logic [TOTAL_W-1:0]  under_total;
      logic [TOTAL_W-1:0]  over_total;
   } fifo_status_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_opcode = '0;
   logic signed [PCM_BITS-1:0] req_left_sample = '0;
   logic signed [PCM_BITS-1:0] req_right_sample = '0;
   logic                       req_last_in_call = 1'b0;
   logic                       rsp_valid;
   logic [OUT_BITS-1:0]        rsp_out_value;
   logic                       rsp_accepted;
   logic                       rsp_underran;
   logic [CNT_W-1:0]           rsp_fill_level;
   logic [CNT_W-1:0]           rsp_free_slots;
   logic [TOTAL_W-1:0]         rsp_underrun_total;
   logic [TOTAL_W-1:0]         rsp_overrun_total;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic                       csr_wdata = 1'b0;

   fifo_cmd_type    cmd_q[$];
   fifo_status_type status_due_q[$];
   logic            req_taken = 1'b0;
   int              idle_pct = 0;

   // predicted block state
   logic [OUT_BITS-1:0] sample_ring [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr;
   logic [PTR_W-1:0]    rd_ptr;
   logic [CNT_W-1:0]    level;
   logic [TOTAL_W-1:0]  under_cnt;
   logic [TOTAL_W-1:0]  over_cnt;
   logic                drop_rest;
   logic                stereo_on;

   int mismatch_count = 0;
   int responses_checked = 0;
   int samples_stored = 0;
   int pushes_refused = 0;
   int underrun_pulls = 0;

   pcm_to_pwm_sample_fifo_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_last_in_call   (req_last_in_call),
      .rsp_valid          (rsp_valid),
      .rsp_out_value      (rsp_out_value),
      .rsp_accepted       (rsp_accepted),
      .rsp_underran       (rsp_underran),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_free_slots     (rsp_free_slots),
      .rsp_underrun_total (rsp_underrun_total),
      .rsp_overrun_total  (rsp_overrun_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   function automatic fifo_status_type fifo_step(fifo_cmd_type c);
      fifo_status_type s;
      int              mix;
      logic [31:0]     biased;
      s = '0;
      case (c.op)
         OP_PUSH: begin
            if (drop_rest) begin
               if (c.last) begin
                  drop_rest = 1'b0;
               end
            end else if (level >= FIFO_DEPTH) begin
               over_cnt  = over_cnt + 1;
               drop_rest = !c.last;
            end else begin
               mix = c.left;
               if (stereo_on) begin
                  mix = (mix + int'(c.right)) / 2;
               end
               biased = mix + 32768;
               sample_ring[wr_ptr] = OUT_BITS'(biased >> (PCM_BITS - OUT_BITS));
               wr_ptr     = wr_ptr + 1'b1;
               level      = level + 1'b1;
               s.accepted = 1'b1;
            end
         end
         OP_PULL: begin
            if (level != 0) begin
               s.value = sample_ring[rd_ptr];
               rd_ptr  = rd_ptr + 1'b1;
               level   = level - 1'b1;
            end else begin
               s.value    = MIDSCALE;
               s.underran = 1'b1;
               under_cnt  = under_cnt + 1;
            end
         end
         OP_CLEAR: begin
            wr_ptr    = '0;
            rd_ptr    = '0;
            level     = '0;
            under_cnt = '0;
            over_cnt  = '0;
            drop_rest = 1'b0;
         end
         default: ;
      endcase
      s.fill        = level;
      s.free        = CNT_W'(FIFO_DEPTH - level);
      s.under_total = under_cnt;
      s.over_total  = over_cnt;
      return s;
   endfunction

   task automatic check_status(fifo_status_type want);
      string tag;
      tag = $sformatf("response %0d", responses_checked);
      if (rsp_out_value !== want.value)
         report_mismatch($sformatf("%s out_value %0d, want %0d", tag, rsp_out_value, want.value));
      if (rsp_accepted !== want.accepted)
         report_mismatch($sformatf("%s accepted %b, want %b", tag, rsp_accepted, want.accepted));
      if (rsp_underran !== want.underran)
         report_mismatch($sformatf("%s underran %b, want %b", tag, rsp_underran, want.underran));
      if (rsp_fill_level !== want.fill)
         report_mismatch($sformatf("%s fill_level %0d, want %0d", tag, rsp_fill_level,
                                   want.fill));
      if (rsp_free_slots !== want.free)
         report_mismatch($sformatf("%s free_slots %0d, want %0d", tag, rsp_free_slots,
                                   want.free));
      if (rsp_underrun_total !== want.under_total)
         report_mismatch($sformatf("%s underrun_total %0d, want %0d", tag,
                                   rsp_underrun_total, want.under_total));
      if (rsp_overrun_total !== want.over_total)
         report_mismatch($sformatf("%s overrun_total %0d, want %0d", tag,
                                   rsp_overrun_total, want.over_total));
   endtask

   always @(posedge clock) begin : monitor
      fifo_cmd_type    taken;
      fifo_status_type want;
      if (reset) begin
         wr_ptr    = '0;
         rd_ptr    = '0;
         level     = '0;
         under_cnt = '0;
         over_cnt  = '0;
         drop_rest = 1'b0;
         stereo_on = 1'b1;
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (status_due_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               check_status(status_due_q.pop_front());
               responses_checked++;
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            taken.op    = opcode_type'(req_opcode);
            taken.left  = req_left_sample;
            taken.right = req_right_sample;
            taken.last  = req_last_in_call;
            taken.hold  = 1'b0;
            want = fifo_step(taken);
            status_due_q.push_back(want);
            if (taken.op == OP_PUSH) begin
               if (want.accepted) samples_stored++;
               else pushes_refused++;
            end
            if (want.underran) underrun_pulls++;
         end
         if (csr_valid && csr_ready) begin
            stereo_on = csr_wdata;
         end
      end
   end

   always @(negedge clock) begin : driver
      fifo_cmd_type next_cmd;
      if (!reset && (!start || req_taken)) begin
         if (cmd_q.size() != 0 && !(cmd_q[0].hold && status_due_q.size() != 0)
             && $urandom_range(99) >= idle_pct) begin
            next_cmd = cmd_q.pop_front();
            start            <= 1'b1;
            req_opcode       <= next_cmd.op;
            req_left_sample  <= next_cmd.left;
            req_right_sample <= next_cmd.right;
            req_last_in_call <= next_cmd.last;
         end else begin
            start            <= 1'b0;
            req_opcode       <= 2'($urandom_range(3));
            req_left_sample  <= PCM_BITS'($urandom_range(65535));
            req_right_sample <= PCM_BITS'($urandom_range(65535));
            req_last_in_call <= 1'($urandom_range(1));
         end
      end
   end

   function automatic void queue_cmd(opcode_type op, int left, int right, logic last,
                                     logic hold);
      fifo_cmd_type c;
      c.op    = op;
      c.left  = PCM_BITS'(left);
      c.right = PCM_BITS'(right);
      c.last  = last;
      c.hold  = hold;
      cmd_q.push_back(c);
   endfunction

   function automatic int rand_pcm();
      case ($urandom_range(7))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   function automatic void queue_pushes(int count);
      repeat (count) begin
         queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'($urandom_range(1)), 1'b0);
      end
   endfunction

   // push calls end on last_in_call, now and then broken, with pulls mixed in
   function automatic void queue_random_mix(int count, int push_pct, int clear_pct);
      int made;
      int pick;
      int len;
      logic hold;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         hold = ($urandom_range(99) == 0);
         if (pick < push_pct) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(),
                         (k == len - 1) ^ ($urandom_range(9) == 0), hold);
               made++;
               if ($urandom_range(4) == 0) begin
                  queue_cmd(OP_PULL, rand_pcm(), rand_pcm(), 1'($urandom_range(1)), 1'b0);
                  made++;
               end
            end
         end else if (pick < 96 - clear_pct) begin
            queue_cmd(OP_PULL, rand_pcm(), rand_pcm(), 1'($urandom_range(1)), hold);
            made++;
         end else if (pick < 100 - clear_pct) begin
            queue_cmd(OP_NOP, rand_pcm(), rand_pcm(), 1'($urandom_range(1)), hold);
            made++;
         end else begin
            queue_cmd(OP_CLEAR, rand_pcm(), rand_pcm(), 1'($urandom_range(1)), hold);
            made++;
         end
      end
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_q.size() != 0 || start || status_due_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_stereo(logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      idle_pct = 8;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stereo mixing from reset, rounding toward zero, every opcode
      queue_cmd(OP_PULL, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, 32767, 32767, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, -32768, -32768, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, -513, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, 0, -513, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, 32767, -32768, 1'b1, 1'b0);
      queue_cmd(OP_NOP, -1, -1, 1'b1, 1'b0);
      repeat (6) queue_cmd(OP_PULL, -1, -1, 1'b1, 1'b0);
      queue_cmd(OP_CLEAR, 12345, -12345, 1'b1, 1'b0);
      wait_idle();

      // left channel only
      write_stereo(1'b0);
      queue_cmd(OP_PUSH, -32768, 32767, 1'b1, 1'b0);
      queue_cmd(OP_PUSH, 32767, -32768, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, 255, -1, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, 256, 0, 1'b1, 1'b0);
      queue_cmd(OP_PULL, 0, 0, 1'b0, 1'b1);
      repeat (4) queue_cmd(OP_PULL, 0, 0, 1'b0, 1'b0);

      // fill to capacity, overrun, drop to end of call, wrap both pointers
      queue_cmd(OP_CLEAR, 0, 0, 1'b0, 1'b0);
      queue_pushes(FIFO_DEPTH);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      queue_cmd(OP_PULL, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      queue_cmd(OP_NOP, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b1, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b1, 1'b0);
      queue_cmd(OP_PULL, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      repeat (FIFO_DEPTH + 1) queue_cmd(OP_PULL, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      wait_idle();

      // near empty, stereo
      write_stereo(1'b1);
      queue_random_mix(170, 25, 2);
      wait_idle();

      // near full, left only: clear mid-call, then hover at capacity
      write_stereo(1'b0);
      idle_pct = 48;
      queue_cmd(OP_CLEAR, 0, 0, 1'b0, 1'b0);
      queue_pushes(FIFO_DEPTH);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      queue_cmd(OP_CLEAR, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_PUSH, rand_pcm(), rand_pcm(), 1'b0, 1'b0);
      queue_pushes(FIFO_DEPTH - 7);
      queue_random_mix(170, 58, 0);
      wait_idle();

      // mixed levels, back-to-back requests
      write_stereo(1'b1);
      idle_pct = 0;
      queue_random_mix(170, 35, 3);
      wait_idle();

      if (status_due_q.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", status_due_q.size()));
      end
      $display("covered %0d requests: %0d samples stored, %0d pushes refused, %0d underruns",
               responses_checked, samples_stored, pushes_refused, underrun_pulls);
      $display("both mixing modes, full ring with overrun and call drop, pointer wrap, clears");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_CYCLES * CLK_PERIOD);
      $display("timeout after %0d cycles", RUN_LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
